// ===== hw/rtl/tcgr_pkg.sv =====
`default_nettype none

package tcgr_pkg;

  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned PIXEL_W     = 16;
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned GROUP_W     = 64;
  localparam int unsigned PITCH_W     = 13;
  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned ROW_W       = 8;
  localparam int unsigned COL_W       = 9;
  localparam int unsigned CHAR_W      = 8;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef logic [PIXEL_W-1:0] rgb565_t;

  // RGB565 of the 16 attribute colors, channels scaled down with truncation
  localparam rgb565_t PALETTE [16] = '{
    16'h0000, 16'h001F, 16'h0620, 16'h07FF,
    16'hF800, 16'hF81F, 16'hA145, 16'hEF9D,
    16'hA534, 16'h8C7C, 16'h8F51, 16'hDFFF,
    16'hFDF8, 16'hFB1F, 16'hFFE0, 16'hFFFF
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_BASE,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/text_cell_glyph_renderer_core.sv =====
// Text cell renderer: draws one 8-pixel-wide glyph cell into an RGB565 frame buffer.
// Input channel (in_valid_i/in_ready_o) takes one beat per item. kind_i = 0 writes
// font_byte_i into the font store at font_index_i and yields nothing; kind_i = 1
// draws the cell at cell_row_i/cell_column_i with character_i and attribute_i.
// A draw yields GLYPH_ROWS * (8 / PIXELS_PER_RESULT) beats on the output channel
// (32 by default), glyph rows top to bottom, groups left to right, last_o on the
// final beat. pixel_address_o is the pixel index of the group's first pixel.
// A draw passes through the pitch multiply and the base add before its first
// beat, then shows one beat per cycle while the receiver takes them; the input
// reopens when the last beat enters the output register. One shared 24-bit adder
// steps the address; the font store has one read port. When the receiver
// stalls, the output register holds its beat and the sequencer waits.
// line_pitch_i is written on the config channel, always ready; the user must
// write it only while idle, which the block itself does not enforce. Reset sets
// the pitch to 1024 and runs a clearing pass over the font store, one byte per
// cycle, with the input channel closed.
`default_nettype none

module text_cell_glyph_renderer_core #(
  parameter int unsigned GLYPH_ROWS        = 16,
  parameter int unsigned GLYPH_COUNT       = 256,
  parameter int unsigned PIXELS_PER_RESULT = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [tcgr_pkg::PITCH_W-1:0]        line_pitch_i,

  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic                                kind_i,
  input  wire logic [tcgr_pkg::INDEX_W-1:0]        font_index_i,
  input  wire logic [7:0]                          font_byte_i,
  input  wire logic [tcgr_pkg::ROW_W-1:0]          cell_row_i,
  input  wire logic [tcgr_pkg::COL_W-1:0]          cell_column_i,
  input  wire logic [tcgr_pkg::CHAR_W-1:0]         character_i,
  input  wire logic [7:0]                          attribute_i,

  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic [tcgr_pkg::ADDR_W-1:0]         pixel_address_o,
  output      logic [tcgr_pkg::GROUP_W-1:0]        pixel_group_o,
  output      logic                                last_o
);

  localparam int unsigned STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned GROUPS      = tcgr_pkg::GLYPH_WIDTH / PIXELS_PER_RESULT;
  localparam int unsigned GRP_W       = $clog2(GROUPS);
  localparam int unsigned GROW_W      = $clog2(GLYPH_ROWS);
  localparam int unsigned ROWG_W      = tcgr_pkg::ROW_W + GROW_W;
  localparam int unsigned ADDR_W      = tcgr_pkg::ADDR_W;

  tcgr_pkg::state_e state_q, state_d;

  logic [AW-1:0]                  clr_cnt_q;
  logic [tcgr_pkg::PITCH_W-1:0]   pitch_q;
  logic [tcgr_pkg::COL_W-1:0]     col_q;
  logic [ROWG_W-1:0]              rowg_q;
  logic [AW-1:0]                  fbase_q;
  tcgr_pkg::rgb565_t              fg_q, bg_q;
  logic [ADDR_W-1:0]              prod_q;
  logic [ADDR_W-1:0]              row_addr_q;
  logic [ADDR_W-1:0]              addr_q;
  logic [GROW_W-1:0]              row_q;
  logic [GRP_W-1:0]               grp_q;
  logic [7:0]                     bits_q;
  logic [7:0]                     rdata_q;

  logic                           out_valid_q;
  logic [ADDR_W-1:0]              out_addr_q;
  logic [tcgr_pkg::GROUP_W-1:0]   out_group_q;
  logic                           out_last_q;

  logic [7:0]                     font_mem [STORE_DEPTH];

  logic                           in_fire;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [7:0]                     mem_wdata;
  logic [AW-1:0]                  rd_addr;
  logic                           out_load;
  logic                           clr_done;
  logic                           last_grp;
  logic                           last_row;
  logic [GROW_W-1:0]              next_row;
  logic [ADDR_W-1:0]              add_a, add_b, add_sum;
  logic [tcgr_pkg::CHAR_W:0]      ch_wide, ch_mod;
  logic [tcgr_pkg::GROUP_W-1:0]   group_d;

  assign in_fire  = in_valid_i && in_ready_o;
  assign clr_done = (clr_cnt_q == AW'(STORE_DEPTH - 1));
  assign last_grp = (grp_q == GRP_W'(GROUPS - 1));
  assign last_row = (row_q == GROW_W'(GLYPH_ROWS - 1));
  assign next_row = last_row ? '0 : row_q + 1'b1;

  // character code modulo glyph count; code is below twice the count
  assign ch_wide = (tcgr_pkg::CHAR_W + 1)'(character_i);
  assign ch_mod  = (ch_wide >= (tcgr_pkg::CHAR_W + 1)'(GLYPH_COUNT)) ?
                   ch_wide - (tcgr_pkg::CHAR_W + 1)'(GLYPH_COUNT) : ch_wide;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcgr_pkg::ST_CLEAR: if (clr_done) state_d = tcgr_pkg::ST_IDLE;
      tcgr_pkg::ST_IDLE:  if (in_fire && kind_i == tcgr_pkg::KIND_DRAW) state_d = tcgr_pkg::ST_MUL;
      tcgr_pkg::ST_MUL:   state_d = tcgr_pkg::ST_BASE;
      tcgr_pkg::ST_BASE:  state_d = tcgr_pkg::ST_EMIT;
      tcgr_pkg::ST_EMIT:  if (out_load && last_grp && last_row) state_d = tcgr_pkg::ST_IDLE;
      default:            state_d = tcgr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_q;
    mem_wdata  = '0;
    out_load   = 1'b0;
    add_a      = addr_q;
    add_b      = ADDR_W'(PIXELS_PER_RESULT);
    rd_addr    = fbase_q;
    case (state_q)
      tcgr_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      tcgr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && kind_i == tcgr_pkg::KIND_LOAD &&
            32'(font_index_i) < STORE_DEPTH) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(font_index_i);
          mem_wdata = font_byte_i;
        end
      end
      tcgr_pkg::ST_MUL: begin
      end
      tcgr_pkg::ST_BASE: begin
        add_a = prod_q;
        add_b = ADDR_W'({col_q, 3'b000});
      end
      tcgr_pkg::ST_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
        // read one glyph row ahead
        rd_addr  = fbase_q + AW'(next_row);
        if (last_grp) begin
          add_a = row_addr_q;
          add_b = ADDR_W'(pitch_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // pixels of the current group, leftmost in the low half-word
  always_comb begin
    logic [2:0] k;
    group_d = '0;
    for (int p = 0; p < PIXELS_PER_RESULT; p++) begin
      k = 3'(int'(grp_q) * PIXELS_PER_RESULT + p);
      group_d[p*tcgr_pkg::PIXEL_W +: tcgr_pkg::PIXEL_W] =
        bits_q[3'(tcgr_pkg::GLYPH_WIDTH - 1) - k] ? fg_q : bg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      font_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= font_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcgr_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      pitch_q     <= tcgr_pkg::PITCH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tcgr_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pitch_q <= line_pitch_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tcgr_pkg::ST_IDLE: begin
        if (in_fire) begin
          col_q   <= cell_column_i;
          rowg_q  <= ROWG_W'(cell_row_i * ROWG_W'(GLYPH_ROWS));
          fbase_q <= AW'(ch_mod * AW'(GLYPH_ROWS));
          fg_q    <= tcgr_pkg::PALETTE[attribute_i[3:0]];
          bg_q    <= tcgr_pkg::PALETTE[attribute_i[7:4]];
          row_q   <= '0;
          grp_q   <= '0;
        end
      end
      tcgr_pkg::ST_MUL: begin
        prod_q <= ADDR_W'(rowg_q) * ADDR_W'(pitch_q);
      end
      tcgr_pkg::ST_BASE: begin
        row_addr_q <= add_sum;
        addr_q     <= add_sum;
        bits_q     <= rdata_q;
      end
      tcgr_pkg::ST_EMIT: begin
        if (out_load) begin
          out_addr_q  <= addr_q;
          out_group_q <= group_d;
          out_last_q  <= last_grp && last_row;
          addr_q      <= add_sum;
          if (last_grp) begin
            row_addr_q <= add_sum;
            row_q      <= next_row;
            grp_q      <= '0;
            bits_q     <= rdata_q;
          end else begin
            grp_q <= grp_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_group_o   = out_group_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;

  localparam int unsigned STORE_DEPTH    = 4096;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RUN_ITEMS      = 24;

  typedef struct {
    logic                         kind;
    logic [tcgr_pkg::INDEX_W-1:0] font_index;
    logic [7:0]                   font_byte;
    logic [tcgr_pkg::ROW_W-1:0]   cell_row;
    logic [tcgr_pkg::COL_W-1:0]   cell_column;
    logic [tcgr_pkg::CHAR_W-1:0]  character;
    logic [7:0]                   attribute;
  } cell_item_t;

  typedef struct {
    logic [tcgr_pkg::ADDR_W-1:0]  address;
    logic [tcgr_pkg::GROUP_W-1:0] group;
    logic                         last;
  } pixel_beat_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [tcgr_pkg::PITCH_W-1:0] line_pitch_i  = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic                         kind_i        = tcgr_pkg::KIND_LOAD;
  logic [tcgr_pkg::INDEX_W-1:0] font_index_i  = '0;
  logic [7:0]                   font_byte_i   = '0;
  logic [tcgr_pkg::ROW_W-1:0]   cell_row_i    = '0;
  logic [tcgr_pkg::COL_W-1:0]   cell_column_i = '0;
  logic [tcgr_pkg::CHAR_W-1:0]  character_i   = '0;
  logic [7:0]                   attribute_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [tcgr_pkg::ADDR_W-1:0]  pixel_address_o;
  logic [tcgr_pkg::GROUP_W-1:0] pixel_group_o;
  logic                         last_o;

  text_cell_glyph_renderer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .line_pitch_i   (line_pitch_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .font_index_i   (font_index_i),
    .font_byte_i    (font_byte_i),
    .cell_row_i     (cell_row_i),
    .cell_column_i  (cell_column_i),
    .character_i    (character_i),
    .attribute_i    (attribute_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_address_o(pixel_address_o),
    .pixel_group_o  (pixel_group_o),
    .last_o         (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cell_item_t                   items_to_send[$];
  cell_item_t                   on_bus;
  pixel_beat_t                  beats_due[$];
  pixel_beat_t                  oldest_beat;
  logic [7:0]                   font_copy [STORE_DEPTH];
  logic [tcgr_pkg::PITCH_W-1:0] pitch_copy = tcgr_pkg::PITCH_RESET;

  int unsigned items_queued  = 0;
  int unsigned items_taken   = 0;
  int unsigned draws_taken   = 0;
  int unsigned beats_checked = 0;
  int unsigned pitch_writes  = 0;
  int unsigned errors        = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_request  = 1'b0;
  bit          hold_done     = 1'b0;

  // 8-bit palette, scaled down to RGB565 with truncating division
  function automatic logic [15:0] rgb565_of(logic [3:0] color);
    logic [23:0] rgb;
    int unsigned r, g, b;
    case (color)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000FF;
      4'd2:    rgb = 24'h00C800;
      4'd3:    rgb = 24'h00FFFF;
      4'd4:    rgb = 24'hFF0000;
      4'd5:    rgb = 24'hFF00FF;
      4'd6:    rgb = 24'hA52A2A;
      4'd7:    rgb = 24'hF5F5F5;
      4'd8:    rgb = 24'hA9A9A9;
      4'd9:    rgb = 24'h9090EE;
      4'd10:   rgb = 24'h90EE90;
      4'd11:   rgb = 24'hE0FFFF;
      4'd12:   rgb = 24'hFFC0CB;
      4'd13:   rgb = 24'hFF64FF;
      4'd14:   rgb = 24'hFFFF00;
      default: rgb = 24'hFFFFFF;
    endcase
    r = (int'(rgb[23:16]) * 31) / 255;
    g = (int'(rgb[15:8]) * 63) / 255;
    b = (int'(rgb[7:0]) * 31) / 255;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // Update the font copy on a load, queue the 32 pixel beats of a draw.
  task automatic predict_item(cell_item_t it);
    logic [15:0]     fg, bg;
    logic [7:0]      bits;
    longint unsigned col_px, row_px, pitch_v, addr;
    pixel_beat_t     beat;
    int              gr, grp, p;
    if (it.kind == tcgr_pkg::KIND_LOAD) begin
      font_copy[it.font_index] = it.font_byte;
    end else begin
      fg      = rgb565_of(it.attribute[3:0]);
      bg      = rgb565_of(it.attribute[7:4]);
      col_px  = 64'(it.cell_column);
      row_px  = 64'(it.cell_row);
      pitch_v = 64'(pitch_copy);
      for (gr = 0; gr < 16; gr++) begin
        bits = font_copy[{it.character, gr[3:0]}];
        for (grp = 0; grp < 2; grp++) begin
          addr = col_px * 8 + (row_px * 16 + 64'(gr)) * pitch_v + 64'(grp * 4);
          beat.address = addr[tcgr_pkg::ADDR_W-1:0];
          beat.group   = '0;
          for (p = 0; p < 4; p++) begin
            beat.group[16*p +: 16] = bits[7 - (grp * 4 + p)] ? fg : bg;
          end
          beat.last = (gr == 15) && (grp == 1);
          beats_due = {beats_due, beat};
        end
      end
    end
  endtask

  // Input channel: hold each beat until taken, refill from the pending items.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_item(on_bus);
        items_taken++;
        if (on_bus.kind == tcgr_pkg::KIND_DRAW) draws_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (items_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = items_to_send.pop_front();
          in_valid_i    <= 1'b1;
          kind_i        <= on_bus.kind;
          font_index_i  <= on_bus.font_index;
          font_byte_i   <= on_bus.font_byte;
          cell_row_i    <= on_bus.cell_row;
          cell_column_i <= on_bus.cell_column;
          character_i   <= on_bus.character;
          attribute_i   <= on_bus.attribute;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output channel: check each beat against the oldest prediction, drive ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (beats_due.size() == 0) begin
          $error("pixel beat with no draw pending: address %h", pixel_address_o);
          errors++;
        end else begin
          oldest_beat = beats_due.pop_front();
          beats_checked++;
          if (pixel_address_o !== oldest_beat.address) begin
            $error("pixel_address: expected %h, got %h", oldest_beat.address,
                   pixel_address_o);
            errors++;
          end
          if (pixel_group_o !== oldest_beat.group) begin
            $error("pixel_group: expected %h, got %h", oldest_beat.group, pixel_group_o);
            errors++;
          end
          if (last_o !== oldest_beat.last) begin
            $error("last: expected %b, got %b", oldest_beat.last, last_o);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_request && !hold_done) begin
        // long back-pressure so the block fills up and closes its input
        out_ready_i <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cell_item_t make_load(logic [tcgr_pkg::INDEX_W-1:0] idx,
                                           logic [7:0] data);
    cell_item_t it;
    it.kind        = tcgr_pkg::KIND_LOAD;
    it.font_index  = idx;
    it.font_byte   = data;
    it.cell_row    = 8'($urandom);
    it.cell_column = 9'($urandom);
    it.character   = 8'($urandom);
    it.attribute   = 8'($urandom);
    return it;
  endfunction

  function automatic cell_item_t make_draw(logic [tcgr_pkg::ROW_W-1:0] row,
                                           logic [tcgr_pkg::COL_W-1:0] col,
                                           logic [tcgr_pkg::CHAR_W-1:0] ch,
                                           logic [7:0] attr);
    cell_item_t it;
    it.kind        = tcgr_pkg::KIND_DRAW;
    it.font_index  = 12'($urandom);
    it.font_byte   = 8'($urandom);
    it.cell_row    = row;
    it.cell_column = col;
    it.character   = ch;
    it.attribute   = attr;
    return it;
  endfunction

  function automatic void queue_item(cell_item_t it);
    items_to_send = {items_to_send, it};
    items_queued++;
  endfunction

  // Mostly: load a few glyph rows of one character, then draw it. Rest is noise.
  task automatic queue_glyph_runs(int unsigned count);
    int unsigned added, rows, r;
    logic [tcgr_pkg::CHAR_W-1:0] ch;
    added = 0;
    while (added < count) begin
      ch = 8'($urandom);
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(1)) queue_item(make_load(12'($urandom), 8'($urandom)));
        else queue_item(make_draw(8'($urandom), 9'($urandom), 8'($urandom),
                                  8'($urandom)));
        added++;
      end else begin
        rows = $urandom_range(1, 4);
        for (r = 0; r < rows; r++) begin
          queue_item(make_load({ch, 4'($urandom)}, 8'($urandom)));
        end
        if ($urandom_range(99) < 80) begin
          queue_item(make_draw(8'($urandom), 9'($urandom), ch, 8'($urandom)));
        end else begin
          queue_item(make_draw(8'($urandom), 9'($urandom), 8'($urandom), 8'($urandom)));
        end
        added += rows + 1;
      end
    end
  endtask

  task automatic write_pitch(logic [tcgr_pkg::PITCH_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i  <= 1'b1;
    line_pitch_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    pitch_copy = value;
    cfg_valid_i <= 1'b0;
    pitch_writes++;
  endtask

  // Sender pause: let every draw finish, then give a trailing load time to land.
  task automatic wait_drained();
    while (items_taken != items_queued || beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) font_copy[i] = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 64;
    write_pitch(tcgr_pkg::PITCH_RESET);

    // font store ends, blank and full rows, every palette entry used as fg or bg
    queue_item(make_load(12'd0, 8'hA5));
    queue_item(make_load(12'd1, 8'hFF));
    queue_item(make_load(12'd15, 8'h00));
    queue_item(make_load(12'd4095, 8'h81));
    queue_item(make_load(12'd4080, 8'h3C));
    queue_item(make_draw(8'd0, 9'd0, 8'd0, 8'h10));
    queue_item(make_draw(8'd255, 9'd511, 8'd255, 8'h32));
    queue_item(make_draw(8'd1, 9'd2, 8'd0, 8'h54));
    queue_item(make_draw(8'd3, 9'd4, 8'd255, 8'h76));
    queue_item(make_draw(8'd17, 9'd100, 8'd0, 8'h98));
    queue_item(make_draw(8'd200, 9'd300, 8'd255, 8'hBA));
    queue_item(make_draw(8'd5, 9'd6, 8'd0, 8'hDC));
    queue_item(make_draw(8'd255, 9'd0, 8'd0, 8'hFE));
    queue_item(make_draw(8'd128, 9'd256, 8'd7, 8'h0F));
    queue_glyph_runs(RUN_ITEMS);

    wait_drained();
    write_pitch(13'd4096);
    hold_request = 1'b1;
    queue_glyph_runs(RUN_ITEMS);

    wait_drained();
    send_idle_pct = 64;
    recv_idle_pct = 33;
    write_pitch(13'd8);
    queue_glyph_runs(RUN_ITEMS);

    wait_drained();
    write_pitch(13'd0);
    queue_glyph_runs(RUN_ITEMS);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_pitch(13'd8191);
    queue_glyph_runs(RUN_ITEMS);

    wait_drained();
    write_pitch(13'($urandom_range(8, 4096)));
    queue_glyph_runs(RUN_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (beats_due.size() != 0) begin
      $error("%0d pixel beats never arrived", beats_due.size());
      errors++;
    end

    $display("run covered %0d items, %0d of them cell draws, %0d pixel beats compared",
             items_taken, draws_taken, beats_checked);
    $display("line pitch set %0d times, including 0, 8, 4096 and 8191", pitch_writes);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tcgr_pkg.sv
hw/rtl/text_cell_glyph_renderer_core.sv
test/testbench.sv
